// ===== rtl/assert_macros.svh =====
// assertion macros used by the sorted list merge datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SLM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/slm_pkg.sv =====
// shared constants and control types for the sorted list merge
package slm_pkg;

    localparam int LIST_DEPTH_DEF = 32;
    localparam int VALUE_BITS_DEF = 32;
    localparam int IO_BITS        = 32;
    localparam int ACTION_BITS    = 2;

    localparam logic [ACTION_BITS-1:0] ACT_LOAD_FIRST  = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_LOAD_SECOND = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_RUN         = 2'd2;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic emit;
        logic finish;
    } t_slm_cmd;

    typedef struct packed {
        logic empty;
        logic out_free;
        logic last_pick;
    } t_slm_stat;

endpackage

// ===== rtl/slm_if.sv =====
// valid/ready channel interfaces for the merge input and result streams
interface slm_in_if import slm_pkg::*;;
    logic                          valid;
    logic                          ready;
    logic [ACTION_BITS-1:0]        action;
    logic signed [IO_BITS-1:0]     value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface slm_out_if import slm_pkg::*;;
    logic                          valid;
    logic                          ready;
    logic signed [IO_BITS-1:0]     merged_value;
    logic                          from_second;
    logic                          last;

    modport source (output valid, output merged_value, output from_second, output last,
                    input ready);
    modport sink   (input valid, input merged_value, input from_second, input last,
                    output ready);
endinterface

// ===== rtl/sorted_list_merge_top.sv =====
// loads: one transaction per cycle while idle, no result; a run with n elements gives n results
// run: the run transaction passes through the prime state into the merge state, then one
// result per cycle, unless stalled, through the single compare and the registered store reads
// merging stalls while the output register holds a result that is not yet taken
// reset (synchronous, active low) empties both lists; store contents are not cleared
module sorted_list_merge_top import slm_pkg::*; #(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    slm_in_if.sink    i_in,
    slm_out_if.source o_res
);

    t_slm_cmd  cmd;
    t_slm_stat stat;

    slm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_action   (i_in.action),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    slm_datapath #(
        .LIST_DEPTH (LIST_DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_value        (i_in.value),
        .i_out_ready    (o_res.ready),
        .o_out_valid    (o_res.valid),
        .o_merged_value (o_res.merged_value),
        .o_from_second  (o_res.from_second),
        .o_last         (o_res.last)
    );

endmodule

// ===== rtl/slm_ctrl.sv =====
// control state machine: load handling and merge sequencing
module slm_ctrl import slm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic [ACTION_BITS-1:0] i_action,
    output logic                   o_in_ready,
    input  t_slm_stat              i_stat,
    output t_slm_cmd               o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PRIME = 2'd1;
    localparam logic [1:0] ST_MERGE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;
    logic       start;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign start      = accept && (i_action == ACT_RUN) && !i_stat.empty;

    always_comb begin
        o_cmd.load_a = accept && (i_action == ACT_LOAD_FIRST);
        o_cmd.load_b = accept && (i_action == ACT_LOAD_SECOND);
        o_cmd.emit   = (r_state == ST_MERGE) && i_stat.out_free;
        o_cmd.finish = o_cmd.emit && i_stat.last_pick;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_PRIME;
            end
            // read data of the first entries settles here
            ST_PRIME: n_state = ST_MERGE;
            ST_MERGE: begin
                if (o_cmd.finish) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/slm_datapath.sv =====
// list stores, read pointers, merge compare and output register
module slm_datapath import slm_pkg::*; #(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_slm_cmd                  i_cmd,
    output t_slm_stat                 o_stat,
    input  logic signed [IO_BITS-1:0] i_value,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic signed [IO_BITS-1:0] o_merged_value,
    output logic                      o_from_second,
    output logic                      o_last
);

    `include "assert_macros.svh"

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(LIST_DEPTH);

    logic [VALUE_BITS-1:0] mem_a [LIST_DEPTH];
    logic [VALUE_BITS-1:0] mem_b [LIST_DEPTH];

    logic [CW-1:0]         r_cnt_a, r_cnt_b, r_idx_a, r_idx_b;
    logic [CW-1:0]         n_cnt_a, n_cnt_b, n_idx_a, n_idx_b;
    logic [VALUE_BITS-1:0] r_rd_a, r_rd_b;
    logic                  r_out_valid;
    logic [IO_BITS-1:0]    r_out_value;
    logic                  r_out_second;
    logic                  r_out_last;

    logic                  wr_a, wr_b;
    logic                  done_a, done_b, take_b;
    logic [VALUE_BITS-1:0] pick;
    logic signed [63:0]    wide_in;
    logic signed [63:0]    wide_out;
    logic [CW:0]           used_next;
    logic [CW:0]           total;

    assign wr_a = i_cmd.load_a && (r_cnt_a < FULL);
    assign wr_b = i_cmd.load_b && (r_cnt_b < FULL);

    assign done_a = (r_idx_a == r_cnt_a);
    assign done_b = (r_idx_b == r_cnt_b);
    // ties go to the first list
    assign take_b = done_a || (!done_b && ($signed(r_rd_b) < $signed(r_rd_a)));
    assign pick   = take_b ? r_rd_b : r_rd_a;

    assign wide_in   = 64'(i_value);
    assign wide_out  = 64'($signed(pick));
    assign used_next = (CW+1)'(r_idx_a) + (CW+1)'(r_idx_b) + (CW+1)'(1);
    assign total     = (CW+1)'(r_cnt_a) + (CW+1)'(r_cnt_b);

    always_comb begin
        o_stat.empty     = (r_cnt_a == '0) && (r_cnt_b == '0);
        o_stat.out_free  = !r_out_valid || i_out_ready;
        o_stat.last_pick = (used_next == total);
    end

    always_comb begin
        n_cnt_a = r_cnt_a;
        n_cnt_b = r_cnt_b;
        n_idx_a = r_idx_a;
        n_idx_b = r_idx_b;
        if (i_cmd.finish) begin
            n_cnt_a = '0;
            n_cnt_b = '0;
            n_idx_a = '0;
            n_idx_b = '0;
        end else begin
            if (wr_a) n_cnt_a = r_cnt_a + CW'(1);
            if (wr_b) n_cnt_b = r_cnt_b + CW'(1);
            if (i_cmd.emit && !take_b) n_idx_a = r_idx_a + CW'(1);
            if (i_cmd.emit && take_b)  n_idx_b = r_idx_b + CW'(1);
        end
    end

    // read at the next pointer so read data always matches the current one
    always_ff @(posedge i_clk) begin
        if (wr_a) mem_a[r_cnt_a[AW-1:0]] <= wide_in[VALUE_BITS-1:0];
        if (wr_b) mem_b[r_cnt_b[AW-1:0]] <= wide_in[VALUE_BITS-1:0];
        r_rd_a <= mem_a[n_idx_a[AW-1:0]];
        r_rd_b <= mem_b[n_idx_b[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_idx_a     <= '0;
            r_idx_b     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
            r_idx_a <= n_idx_a;
            r_idx_b <= n_idx_b;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_value  <= wide_out[IO_BITS-1:0];
            r_out_second <= take_b;
            r_out_last   <= o_stat.last_pick;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_merged_value = r_out_value;
    assign o_from_second  = r_out_second;
    assign o_last         = r_out_last;

    `SLM_ASSERT_SAME(a_idx_a_bound, 1'b1, r_idx_a <= r_cnt_a, "first read pointer past count")
    `SLM_ASSERT_SAME(a_idx_b_bound, 1'b1, r_idx_b <= r_cnt_b, "second read pointer past count")
    `SLM_ASSERT_SAME(a_emit_has_data, i_cmd.emit, !(done_a && done_b), "emit with both lists used")
    `SLM_ASSERT_NEXT(a_last_marked, i_cmd.finish, r_out_valid && r_out_last && r_idx_a == '0,
                     "final transaction not marked last")

endmodule
